// ===== rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared widths, defaults and controller states for the box blur row pass.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int PIX_W             = 8;
  localparam int RAD_W             = 5;
  localparam int SUM_W             = 14;
  localparam int DIV_W             = RAD_W + 1;
  localparam int DVD_W             = SUM_W + 1;
  localparam int RING_DEPTH_DEF    = 64;
  localparam int MAX_ROW_WIDTH_DEF = 4096;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/bbr_if.sv =====
// ----------------------------------------------------------------------------
// bbr_if
// Valid/ready stream channels for input pixels and blurred output pixels.
// ----------------------------------------------------------------------------
interface bbr_in_if;
  logic                     valid;
  logic                     ready;
  logic [bbr_pkg::PIX_W-1:0] pixel;
  logic                     row_end;

  modport source (output valid, output pixel, output row_end, input ready);
  modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

interface bbr_out_if;
  logic                     valid;
  logic                     ready;
  logic [bbr_pkg::PIX_W-1:0] blurred;
  logic                     row_done;

  modport source (output valid, output blurred, output row_done, input ready);
  modport sink   (input valid, input blurred, input row_done, output ready);
endinterface

// ===== rtl/box_blur_row_pass_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_row_pass_core
// Horizontal box blur with edge clamp over a pixel ring held in a sync RAM.
// ----------------------------------------------------------------------------
// an input word that yields no result passes through the add state before the next is taken
// an input word with a result also passes the 8-step serial divider and the output state
// a result word is loaded once the divider is done and the output word register is free
// a row end flushes up to the clamped radius more results before the next word
// reset: radius 1, row position and window sum cleared, ring contents undefined
module box_blur_row_pass_core #(
  parameter int RING_DEPTH    = bbr_pkg::RING_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = bbr_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      radius_we,
  input  logic [bbr_pkg::RAD_W-1:0] radius_wdata,
  bbr_in_if.sink                    in_ch,
  bbr_out_if.source                 out_ch
);

  localparam int PW   = bbr_pkg::PIX_W;
  localparam int RDW  = bbr_pkg::RAD_W;
  localparam int SW   = bbr_pkg::SUM_W;
  localparam int DW   = bbr_pkg::DIV_W;
  localparam int AW   = $clog2(RING_DEPTH);
  localparam int NW   = $clog2(MAX_ROW_WIDTH);
  localparam int XW   = (AW > DW ? AW : DW) + 1;
  localparam int CAP  = (RING_DEPTH - 1) / 2;
  localparam int RMAX = (2 ** RDW) - 1;
  localparam int CAPC = CAP > RMAX ? RMAX : CAP;
  localparam logic [RDW-1:0] CAP_R = RDW'(CAPC);

  bbr_pkg::state_t state, state_next;

  logic [RDW-1:0] radius;
  logic [NW-1:0]  n;
  logic [SW-1:0]  sum;
  logic [PW-1:0]  first;
  logic [AW-1:0]  slot;
  logic [PW-1:0]  p_q;
  logic           last_q;
  logic [RDW-1:0] m;

  logic [PW-1:0]  ring [RING_DEPTH];
  logic [PW-1:0]  rd_data;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  slot_new;

  logic [RDW-1:0] r_eff;
  logic [DW-1:0]  d;
  logic           accept;
  logic           in_ready;
  logic           emit;
  logic           use_ring;
  logic           more;
  logic           out_free;
  logic           load_out;
  logic           adv;
  logic           div_start;
  logic           div_done;
  logic [PW-1:0]  quotient;
  logic [PW-1:0]  x;
  logic [SW-1:0]  sum_next;
  logic [DW+PW-1:0] prod;
  logic [bbr_pkg::DVD_W-1:0] dividend;
  logic [NW:0]    nm;
  logic [DW-1:0]  rd_k;
  logic [DW-1:0]  back_k;
  logic [AW-1:0]  rd_base;
  logic [XW-1:0]  base_x;
  logic [XW-1:0]  back_x;
  logic [XW-1:0]  addr_x;
  logic           out_valid;
  logic [PW-1:0]  blurred;
  logic           row_done;

  assign r_eff  = (radius > CAP_R) ? CAP_R : radius;
  assign d      = {r_eff, 1'b1};
  assign accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign nm       = (NW+1)'(n) + (NW+1)'(m);
  assign emit     = nm >= (NW+1)'(r_eff);
  assign use_ring = nm >= (NW+1)'(d);
  assign more     = last_q && (m < r_eff);
  assign out_free = !out_valid || out_ch.ready;

  // ring addressing
  always_comb begin
    if (n == '0) begin
      slot_new = '0;
    end else if (slot == AW'(RING_DEPTH - 1)) begin
      slot_new = '0;
    end else begin
      slot_new = slot + AW'(1);
    end
  end

  assign rd_base = slot;
  assign rd_k    = (state == bbr_pkg::ST_IDLE) ? DW'(1) : DW'(m) + DW'(1);
  assign back_k  = d - rd_k;
  assign base_x  = XW'(rd_base);
  assign back_x  = XW'(back_k);
  assign addr_x  = (base_x >= back_x) ? base_x - back_x
                                      : base_x + XW'(RING_DEPTH) - back_x;
  assign rd_addr = addr_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[slot_new] <= in_ch.pixel;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
  end

  // window update
  assign prod = d * p_q;
  assign x    = use_ring ? rd_data : first;

  always_comb begin
    if (n == '0 && m == '0) begin
      sum_next = SW'(prod);
    end else begin
      sum_next = sum + SW'(p_q) - SW'(x);
    end
  end

  assign dividend = bbr_pkg::DVD_W'(sum_next) + bbr_pkg::DVD_W'(r_eff);

  bbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (d),
    .done     (div_done),
    .quotient (quotient)
  );

  // controller
  always_comb begin
    state_next = state;
    unique case (state)
      bbr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bbr_pkg::ST_ADD;
        end
      end
      bbr_pkg::ST_ADD: begin
        if (emit) begin
          state_next = bbr_pkg::ST_DIV;
        end else if (more) begin
          state_next = bbr_pkg::ST_ADD;
        end else begin
          state_next = bbr_pkg::ST_IDLE;
        end
      end
      bbr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = bbr_pkg::ST_OUT;
        end
      end
      bbr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = more ? bbr_pkg::ST_ADD : bbr_pkg::ST_IDLE;
        end
      end
      default: state_next = bbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == bbr_pkg::ST_IDLE;
    div_start = (state == bbr_pkg::ST_ADD) && emit;
    load_out  = (state == bbr_pkg::ST_OUT) && out_free;
    adv       = ((state == bbr_pkg::ST_ADD) && !emit) || load_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= bbr_pkg::RADIUS_RST;
      n      <= '0;
      sum    <= '0;
      first  <= '0;
      slot   <= '0;
      m      <= '0;
    end else begin
      if (radius_we) begin
        radius <= radius_wdata;
        n      <= '0;
        sum    <= '0;
      end
      if (accept) begin
        slot <= slot_new;
        m    <= '0;
      end
      if (state == bbr_pkg::ST_ADD) begin
        sum <= sum_next;
        if (n == '0 && m == '0) begin
          first <= p_q;
        end
      end
      if (adv) begin
        if (more) begin
          m <= m + RDW'(1);
        end else if (last_q) begin
          n   <= '0;
          sum <= '0;
        end else if (n != NW'(MAX_ROW_WIDTH - 1)) begin
          n <= n + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_q    <= in_ch.pixel;
      last_q <= in_ch.row_end;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      blurred  <= quotient;
      row_done <= last_q && (m == r_eff);
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.blurred  = blurred;
  assign out_ch.row_done = row_done;

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    state == bbr_pkg::ST_ADD |-> m <= r_eff)
    else $error("flush counter past radius");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == bbr_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_row_close: assert property (@(posedge clk) disable iff (rst)
    load_out && last_q && (m == r_eff) && !radius_we |=> n == '0 && sum == '0)
    else $error("row state not cleared after last word");

endmodule

// ===== rtl/bbr_div.sv =====
// ----------------------------------------------------------------------------
// bbr_div
// Restoring divider, one quotient bit per cycle, quotient known to fit.
// ----------------------------------------------------------------------------
module bbr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bbr_pkg::DVD_W-1:0]  dividend,
  input  logic [bbr_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [bbr_pkg::PIX_W-1:0]  quotient
);

  localparam int QW  = bbr_pkg::PIX_W;
  localparam int RW  = bbr_pkg::DVD_W - QW;
  localparam int CW  = $clog2(QW);

  logic [RW-1:0]   rem;
  logic [QW-1:0]   shreg;
  logic [CW-1:0]   cnt;
  logic            running;
  logic [RW:0]     trial;
  logic            ge;
  logic [RW:0]     diff;

  assign trial = {rem, shreg[QW-1]};
  assign ge    = trial >= (RW+1)'(divisor);
  assign diff  = trial - (RW+1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[bbr_pkg::DVD_W-1 -: RW];
      shreg <= dividend[QW-1:0];
    end else if (running) begin
      rem   <= ge ? diff[RW-1:0] : trial[RW-1:0];
      shreg <= {shreg[QW-2:0], ge};
    end
  end

  assign quotient = shreg;

endmodule
